// File: rtl/core/kswg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kswg_pkg
// Shared types and constants of the keyed splitmix weight generator.
// ----------------------------------------------------------------------------
package kswg_pkg;

  localparam int unsigned HashW   = 64;
  localparam int unsigned FloatW  = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned OutW    = 96;

  localparam logic [HashW-1:0]  FnvLow     = 64'h0000_0000_0000_01B3;
  localparam logic [HashW-1:0]  GoldenInc  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [HashW-1:0]  MixMulA    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [HashW-1:0]  MixMulB    = 64'h94D0_49BB_1331_11EB;
  localparam logic [FloatW-1:0] QNanBits   = 32'h7FC0_0000;
  localparam logic [FloatW-1:0] ScaleReset = 32'h3F80_0000;

  localparam logic [CmdW-1:0] CMD_START  = 2'd0;
  localparam logic [CmdW-1:0] CMD_ABSORB = 2'd1;
  localparam logic [CmdW-1:0] CMD_GEN    = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_SEED  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SCALE = 1'd1;

  typedef enum logic [1:0] {
    OP_START,
    OP_ABSORB,
    OP_GEN
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] key_byte;
  } q_entry_t;

endpackage

// File: rtl/core/kswg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kswg_front
// Accept commands, drop unused codes and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module kswg_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // key_byte
  input  logic [1:0]                s_axis_tuser,  // command
  output kswg_pkg::q_entry_t        head_o,
  output logic                      head_valid_o,
  input  logic                      pop_i
);
  import kswg_pkg::*;

  q_entry_t e0_q, e0_d, e1_q, e1_d, in_entry;
  logic     v0_q, v0_d, v1_q, v1_d;
  logic     keep;

  assign s_axis_tready = !v1_q;

  always_comb begin
    keep = 1'b1;
    in_entry.key_byte = s_axis_tdata;
    in_entry.op = OP_START;
    case (s_axis_tuser)
      CMD_START:  in_entry.op = OP_START;
      CMD_ABSORB: in_entry.op = OP_ABSORB;
      CMD_GEN:    in_entry.op = OP_GEN;
      default:    keep = 1'b0;
    endcase
  end

  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    e0_d = e0_q;
    e1_d = e1_q;
    if (pop_i) begin
      v0_d = v1_q;
      e0_d = e1_q;
      v1_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready && keep) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        e0_d = in_entry;
      end else begin
        v1_d = 1'b1;
        e1_d = in_entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      e0_q <= '0;
      e1_q <= '0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      e0_q <= e0_d;
      e1_q <= e1_d;
    end
  end

  assign head_o       = e0_q;
  assign head_valid_o = v0_q;

endmodule

// File: rtl/core/kswg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kswg_back
// Run hash updates, the splitmix64 finalizer and the float32 value path.
// ----------------------------------------------------------------------------
module kswg_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kswg_pkg::q_entry_t        head_i,
  input  logic                      head_valid_i,
  output logic                      pop_o,
  input  logic [63:0]               seed_i,
  input  logic [31:0]               scale_i,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [95:0]               m_axis_tdata  // value_bits, mixed_word
);
  import kswg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NORM, S_DENORM, S_ROUND, S_SUB, S_MULF, S_PREP, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_U, PH_V, PH_R
  } phase_e;

  state_e             state_q;
  phase_e             phase_q;
  logic [63:0]        hash_q, acc_q, mulb_q, prod_q, p0_q, z_q;
  logic [31:0]        cross_q, res_bits_q;
  logic [1:0]         mc_q;
  logic               second_q;
  logic [79:0]        w_q;
  logic signed [9:0]  x_q, xu_q, xv_q;
  logic               sign_q, sv_q, vz_q;
  logic [23:0]        mu_q, mv_q;
  logic [47:0]        pp_q;
  logic               out_valid_q;
  logic [95:0]        out_data_q;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod, mulres, gen_h, absorb_h;
  logic [23:0]        mant24, mr;
  logic [24:0]        r25;
  logic               rnd_up, wz;
  logic signed [9:0]  xr, ebias, es;
  logic [31:0]        enc;
  logic [5:0]         sh;
  logic [80:0]        t81;
  logic [79:0]        diff;
  logic               neg;
  logic [23:0]        ms;
  logic [7:0]         sexp;
  logic [22:0]        sfrac;

  always_comb begin
    case (mc_q)
      2'd0:    begin mul_a = acc_q[31:0];  mul_b = mulb_q[31:0];  end
      2'd1:    begin mul_a = acc_q[31:0];  mul_b = mulb_q[63:32]; end
      default: begin mul_a = acc_q[63:32]; mul_b = mulb_q[31:0];  end
    endcase
    prod     = 64'(mul_a) * 64'(mul_b);
    mulres   = p0_q + {cross_q + prod_q[31:0], 32'd0};
    gen_h    = hash_q + GoldenInc;
    absorb_h = ((hash_q << 40) + 64'(hash_q * FnvLow)) ^ 64'(head_i.key_byte);
  end

  always_comb begin
    mant24 = w_q[79:56];
    rnd_up = w_q[55] & ((|w_q[54:0]) | w_q[56]);
    r25    = {1'b0, mant24} + 25'(rnd_up);
    wz     = (w_q == '0);
    if (r25[24]) begin
      mr = 24'h80_0000;
      xr = x_q + 10'sd1;
    end else begin
      mr = r25[23:0];
      xr = x_q;
    end
    ebias = xr + 10'sd127;
    if (!mr[23]) begin
      enc = {sign_q, 8'd0, mr[22:0]};
    end else if (ebias >= 10'sd255) begin
      enc = {sign_q, 8'hFF, 23'd0};
    end else begin
      enc = {sign_q, ebias[7:0], mr[22:0]};
    end
  end

  always_comb begin
    sh  = 6'(xu_q + 10'sd57);
    t81 = 81'(mu_q) << sh;
    neg = !(t81 >= (81'd1 << 79));
    if (neg) begin
      diff = 80'((81'd1 << 79) - t81);
    end else begin
      diff = 80'(t81 - (81'd1 << 79));
    end
  end

  always_comb begin
    sexp  = scale_i[30:23];
    sfrac = scale_i[22:0];
    if (sexp == 8'd0) begin
      ms = {1'b0, sfrac};
      es = -10'sd126;
    end else begin
      ms = {1'b1, sfrac};
      es = $signed({2'b00, sexp}) - 10'sd127;
    end
  end

  assign pop_o = (state_q == S_IDLE) && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_U;
      hash_q      <= '0;
      acc_q       <= '0;
      mulb_q      <= '0;
      prod_q      <= '0;
      p0_q        <= '0;
      z_q         <= '0;
      cross_q     <= '0;
      res_bits_q  <= '0;
      mc_q        <= '0;
      second_q    <= 1'b0;
      w_q         <= '0;
      x_q         <= '0;
      xu_q        <= '0;
      xv_q        <= '0;
      sign_q      <= 1'b0;
      sv_q        <= 1'b0;
      vz_q        <= 1'b0;
      mu_q        <= '0;
      mv_q        <= '0;
      pp_q        <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (head_valid_i) begin
            case (head_i.op)
              OP_START:  hash_q <= seed_i;
              OP_ABSORB: hash_q <= absorb_h;
              OP_GEN: begin
                hash_q   <= gen_h;
                acc_q    <= gen_h ^ (gen_h >> 30);
                mulb_q   <= MixMulA;
                second_q <= 1'b0;
                mc_q     <= 2'd0;
                state_q  <= S_MUL;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          mc_q <= mc_q + 2'd1;
          case (mc_q)
            2'd0: prod_q <= prod;
            2'd1: begin
              p0_q   <= prod_q;
              prod_q <= prod;
            end
            2'd2: begin
              cross_q <= prod_q[31:0];
              prod_q  <= prod;
            end
            default: begin
              if (!second_q) begin
                acc_q    <= mulres ^ (mulres >> 27);
                mulb_q   <= MixMulB;
                second_q <= 1'b1;
              end else begin
                z_q     <= mulres ^ (mulres >> 31);
                w_q     <= {mulres[63:11] ^ mulres[63:42], 27'd0};
                x_q     <= -10'sd1;
                sign_q  <= 1'b0;
                phase_q <= PH_U;
                state_q <= S_NORM;
              end
            end
          endcase
        end
        S_NORM: begin
          if (wz) begin
            state_q <= S_ROUND;
          end else if (!w_q[79]) begin
            w_q <= {w_q[78:0], 1'b0};
            x_q <= x_q - 10'sd1;
          end else begin
            state_q <= S_DENORM;
          end
        end
        S_DENORM: begin
          if (x_q < -10'sd126) begin
            w_q <= {1'b0, w_q[79:2], w_q[1] | w_q[0]};
            x_q <= x_q + 10'sd1;
          end else begin
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          case (phase_q)
            PH_U: begin
              mu_q    <= wz ? 24'd0 : mr;
              xu_q    <= wz ? 10'sd0 : xr;
              state_q <= S_SUB;
            end
            PH_V: begin
              mv_q    <= mr;
              xv_q    <= xr;
              sv_q    <= sign_q;
              vz_q    <= wz;
              state_q <= S_MULF;
            end
            default: begin
              res_bits_q <= enc;
              state_q    <= S_OUT;
            end
          endcase
        end
        S_SUB: begin
          w_q     <= diff;
          x_q     <= 10'sd0;
          sign_q  <= neg;
          phase_q <= PH_V;
          state_q <= S_NORM;
        end
        S_MULF: begin
          pp_q    <= 48'(mv_q) * 48'(ms);
          state_q <= S_PREP;
        end
        S_PREP: begin
          if (sexp == 8'hFF && sfrac != '0) begin
            res_bits_q <= QNanBits;
            state_q    <= S_OUT;
          end else if (sexp == 8'hFF) begin
            res_bits_q <= vz_q ? QNanBits : {sv_q ^ scale_i[31], 8'hFF, 23'd0};
            state_q    <= S_OUT;
          end else if (vz_q || (sexp == 8'd0 && sfrac == '0)) begin
            res_bits_q <= {sv_q ^ scale_i[31], 31'd0};
            state_q    <= S_OUT;
          end else begin
            w_q     <= {pp_q, 32'd0};
            x_q     <= xv_q + es + 10'sd1;
            sign_q  <= sv_q ^ scale_i[31];
            phase_q <= PH_R;
            state_q <= S_NORM;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {z_q, res_bits_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/core/keyed_splitmix_weight_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_splitmix_weight_generator
// Keyed splitmix64 hash with a float32 scaled weight output.
// ----------------------------------------------------------------------------
// Start and absorb update the hash from the idle state of the back engine.
// Generate runs on the 32x32 multiplier shared over three passes per
// 64-bit product and on the one-bit-per-cycle normalize and denormalize
// shifter.
// A two-entry queue takes new commands while the engine works.
// Reset clears hash and seed to zero and the scale to 1.0.
module keyed_splitmix_weight_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // key_byte
  input  logic [1:0]   s_axis_tuser,   // command
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // value_bits[31:0], mixed_word[95:32]
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i
);
  import kswg_pkg::*;

  logic [63:0] seed_q;
  logic [31:0] scale_q;
  q_entry_t    head;
  logic        head_valid;
  logic        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEED:  seed_q  <= cfg_data_i;
        REG_SCALE: scale_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  kswg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  kswg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .seed_i       (seed_q),
    .scale_i      (scale_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid) else $error("pop from empty queue");

  a_queue_keeps_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid && !pop |=> head_valid) else $error("queue lost an entry");

endmodule
